FILE: rtl/prl_pkg.sv
`timescale 1ns / 1ps

package prl_pkg;

  // list geometry
  localparam int CAPACITY_DEF = 64;
  localparam int NAME_CHARS   = 15;

  // request kinds
  localparam logic [2:0] KIND_INS_AT    = 3'd0;
  localparam logic [2:0] KIND_INS_FIRST = 3'd1;
  localparam logic [2:0] KIND_INS_LAST  = 3'd2;
  localparam logic [2:0] KIND_DEL_AT    = 3'd3;
  localparam logic [2:0] KIND_DEL_FIRST = 3'd4;
  localparam logic [2:0] KIND_DEL_LAST  = 3'd5;
  localparam logic [2:0] KIND_READ_AT   = 3'd6;

  // result status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BADPOS = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  // request transaction
  typedef struct packed {
    logic [2:0]  kind;
    logic [6:0]  position;
    logic [63:0] name_upper;
    logic [55:0] name_lower;
    logic [30:0] post_count;
    logic [31:0] follower_count;
  } in_t;

  // result transaction
  typedef struct packed {
    logic [1:0]  status;
    logic [6:0]  entry_total;
    logic [63:0] out_name_upper;
    logic [55:0] out_name_lower;
    logic [30:0] out_post_count;
    logic [31:0] out_follower_count;
  } out_t;

  // one stored record
  typedef struct packed {
    logic [63:0] name_upper;
    logic [55:0] name_lower;
    logic [30:0] post_count;
    logic [31:0] follower_count;
  } rec_t;

  // byte masks that keep only the first chars name characters
  function automatic logic [63:0] upper_keep(int chars);
    logic [63:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      if (i < chars) m[63-8*i -: 8] = 8'hFF;
    end
    return m;
  endfunction

  function automatic logic [55:0] lower_keep(int chars);
    logic [55:0] m;
    m = '0;
    for (int i = 0; i < 7; i++) begin
      if (8 + i < chars) m[55-8*i -: 8] = 8'hFF;
    end
    return m;
  endfunction

  localparam logic [63:0] UPPER_KEEP = upper_keep(NAME_CHARS);
  localparam logic [55:0] LOWER_KEEP = lower_keep(NAME_CHARS);

endpackage

FILE: rtl/positional_record_list_core.sv
`timescale 1ns / 1ps

// Ordered list of up to CAPACITY records (15-character name, post count,
// follower count) with read by 1-based position and insert and delete by
// position, at the front or at the end. Each request transaction gives one
// result transaction with a status, the new record count and, for delete
// and read, the record taken. A request is taken only while the block is
// idle and runs to completion before the next one. An insert moves the
// entries from the end down to its position one place up and then writes
// the new record, or only writes it when it lands at the end; a delete
// reads the record taken and moves the later entries one place down; a
// read fetches the one record; a rejected request goes straight to its
// result. The record memory has one read and one write port, so entries
// shift by one place per cycle. A finished result waits in an output
// register and the block returns to idle once it is placed there.
module positional_record_list_core #(
  parameter int CAPACITY = prl_pkg::CAPACITY_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          request_valid,
  output logic          request_stall,
  input  prl_pkg::in_t  request,
  output logic          result_valid,
  input  logic          result_stall,
  output prl_pkg::out_t result
);
  import prl_pkg::*;

  localparam int AW = $clog2(CAPACITY);

  logic          res_valid;
  logic          res_free;
  out_t          res;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  rec_t          mem_wdata;
  logic [AW-1:0] mem_raddr;
  rec_t          mem_rdata;

  prl_seq #(
    .CAPACITY (CAPACITY)
  ) u_seq (
    .clk           (clk),
    .rst           (rst),
    .request_valid (request_valid),
    .request_stall (request_stall),
    .request       (request),
    .res_valid     (res_valid),
    .res_free      (res_free),
    .res           (res),
    .mem_we        (mem_we),
    .mem_waddr     (mem_waddr),
    .mem_wdata     (mem_wdata),
    .mem_raddr     (mem_raddr),
    .mem_rdata     (mem_rdata)
  );

  prl_store #(
    .CAPACITY (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // output register, free when empty or being taken
  assign res_free = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res_valid && res_free) begin
      result_valid <= 1'b1;
      result       <= res;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

endmodule

FILE: rtl/prl_store.sv
`timescale 1ns / 1ps

module prl_store #(
  parameter int CAPACITY = prl_pkg::CAPACITY_DEF,
  localparam int AW = $clog2(CAPACITY)
) (
  input  logic           clk,
  input  logic           we,
  input  logic [AW-1:0]  waddr,
  input  prl_pkg::rec_t  wdata,
  input  logic [AW-1:0]  raddr,
  output prl_pkg::rec_t  rdata
);
  import prl_pkg::*;

  rec_t mem [CAPACITY];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/prl_seq.sv
`timescale 1ns / 1ps

module prl_seq #(
  parameter int CAPACITY = prl_pkg::CAPACITY_DEF,
  localparam int AW = $clog2(CAPACITY),
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           request_valid,
  output logic           request_stall,
  input  prl_pkg::in_t   request,
  output logic           res_valid,
  input  logic           res_free,
  output prl_pkg::out_t  res,
  output logic           mem_we,
  output logic [AW-1:0]  mem_waddr,
  output prl_pkg::rec_t  mem_wdata,
  output logic [AW-1:0]  mem_raddr,
  input  prl_pkg::rec_t  mem_rdata
);
  import prl_pkg::*;

  localparam int PW = ((CW > 7) ? CW : 7) + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_DEL,
    S_DRAIN,
    S_WNEW,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_INS,
    OP_DEL,
    OP_READ
  } op_t;

  state_t          state;
  logic [CW-1:0]   count;
  logic [CW-1:0]   count_next;
  logic [AW-1:0]   cur;
  logic [AW-1:0]   last;
  logic [AW-1:0]   idx;
  logic            pend;
  logic            pend_cap;
  logic [AW-1:0]   pend_dst;
  logic            grow;
  logic            shrink;
  logic [1:0]      status;
  rec_t            new_rec;
  rec_t            res_rec;

  logic [PW-1:0]   pos_w;
  logic [PW-1:0]   cnt_w;
  logic            full;
  logic            empty;
  logic [1:0]      d_status;
  logic [AW-1:0]   d_idx;
  op_t             d_op;

  // request decode against the current count
  always_comb begin
    pos_w    = PW'(request.position);
    cnt_w    = PW'(count);
    full     = (cnt_w == PW'(CAPACITY));
    empty    = (count == '0);
    d_status = ST_OK;
    d_idx    = '0;
    d_op     = OP_NONE;
    case (request.kind)
      KIND_INS_AT: begin
        if (full) d_status = ST_FULL;
        else if (pos_w == '0 || pos_w > cnt_w + PW'(1)) d_status = ST_BADPOS;
        else begin
          d_op  = OP_INS;
          d_idx = AW'(pos_w - PW'(1));
        end
      end
      KIND_INS_FIRST: begin
        if (full) d_status = ST_FULL;
        else d_op = OP_INS;
      end
      KIND_INS_LAST: begin
        if (full) d_status = ST_FULL;
        else begin
          d_op  = OP_INS;
          d_idx = AW'(count);
        end
      end
      KIND_DEL_AT, KIND_READ_AT: begin
        if (empty) d_status = ST_EMPTY;
        else if (pos_w == '0 || pos_w > cnt_w) d_status = ST_BADPOS;
        else begin
          d_op  = (request.kind == KIND_READ_AT) ? OP_READ : OP_DEL;
          d_idx = AW'(pos_w - PW'(1));
        end
      end
      KIND_DEL_FIRST: begin
        if (empty) d_status = ST_EMPTY;
        else d_op = OP_DEL;
      end
      KIND_DEL_LAST: begin
        if (empty) d_status = ST_EMPTY;
        else begin
          d_op  = OP_DEL;
          d_idx = AW'(count - CW'(1));
        end
      end
      default: begin
        d_op = OP_NONE;
      end
    endcase
  end

  // memory port: shift moves, then the new record
  assign mem_raddr = cur;
  assign mem_we    = (state == S_WNEW) || (pend && !pend_cap);
  assign mem_waddr = (state == S_WNEW) ? idx : pend_dst;
  assign mem_wdata = (state == S_WNEW) ? new_rec : mem_rdata;

  // result toward the output register
  assign count_next = grow ? count + CW'(1) : (shrink ? count - CW'(1) : count);
  assign res_valid  = (state == S_DONE);
  assign request_stall = (state != S_IDLE);

  always_comb begin
    res.status             = status;
    res.entry_total        = 7'(count_next);
    res.out_name_upper     = res_rec.name_upper;
    res.out_name_lower     = res_rec.name_lower;
    res.out_post_count     = res_rec.post_count;
    res.out_follower_count = res_rec.follower_count;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      pend   <= 1'b0;
      grow   <= 1'b0;
      shrink <= 1'b0;
    end else begin
      // returning read data: either the result record or a move
      if (pend && pend_cap) begin
        res_rec <= mem_rdata;
      end
      case (state)
        S_IDLE: begin
          if (request_valid) begin
            status                 <= d_status;
            idx                    <= d_idx;
            res_rec                <= '0;
            pend                   <= 1'b0;
            pend_cap               <= 1'b0;
            grow                   <= (d_op == OP_INS);
            shrink                 <= (d_op == OP_DEL);
            new_rec.name_upper     <= request.name_upper & UPPER_KEEP;
            new_rec.name_lower     <= request.name_lower & LOWER_KEEP;
            new_rec.post_count     <= request.post_count;
            new_rec.follower_count <= request.follower_count;
            case (d_op)
              OP_INS: begin
                if (CW'(d_idx) == count) begin
                  state <= S_WNEW;
                end else begin
                  cur   <= AW'(count - CW'(1));
                  last  <= d_idx;
                  state <= S_INS;
                end
              end
              OP_DEL: begin
                cur   <= d_idx;
                last  <= AW'(count - CW'(1));
                state <= S_DEL;
              end
              OP_READ: begin
                cur   <= d_idx;
                last  <= d_idx;
                state <= S_DEL;
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_INS: begin
          // walk down, each entry moves one place up
          pend     <= 1'b1;
          pend_cap <= 1'b0;
          pend_dst <= cur + AW'(1);
          if (cur == last) state <= S_DRAIN;
          else cur <= cur - AW'(1);
        end
        S_DEL: begin
          // walk up, first read is the result, later ones move one place down
          pend     <= 1'b1;
          pend_cap <= (cur == idx);
          pend_dst <= cur - AW'(1);
          if (cur == last) state <= S_DRAIN;
          else cur <= cur + AW'(1);
        end
        S_DRAIN: begin
          pend     <= 1'b0;
          pend_cap <= 1'b0;
          state    <= grow ? S_WNEW : S_DONE;
        end
        S_WNEW: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (res_free) begin
            count  <= count_next;
            grow   <= 1'b0;
            shrink <= 1'b0;
            state  <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // the count stays within the list size
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    CW'(CAPACITY) >= count)
    else $error("record count above capacity");

  // shifts only read entries that hold records
  a_read_live: assert property (@(posedge clk) disable iff (rst)
    (state == S_INS || state == S_DEL) |-> CW'(cur) < count)
    else $error("shift reads past the last record");

  // writes never land beyond the end of the list
  a_write_live: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> CW'(mem_waddr) <= count)
    else $error("write beyond the end of the list");

  // the count moves only when a result is handed over
  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    !(state == S_DONE && res_free) |=> $stable(count))
    else $error("count changed outside result handover");

  // insert and remove never both apply
  a_one_delta: assert property (@(posedge clk) disable iff (rst)
    !(grow && shrink))
    else $error("insert and remove flagged together");

endmodule
